@@ hw/rtl/i8p_pkg.sv @@
// Shared types, constants and field-list decoders for the ISO 8583 response parser.
package i8p_pkg;

  localparam logic [4:0] SLOT_CNT = 5'd21;  // entries in the supported field list
  localparam logic [4:0] HDR_LEN  = 5'd26;  // length prefix + MTI + both bitmaps
  localparam logic [4:0] MTI_END  = 5'd10;  // first bitmap byte position
  localparam logic [4:0] PRIM_END = 5'd18;  // first secondary bitmap byte position

  localparam logic [6:0] FNUM_PRIMARY   = 7'd0;
  localparam logic [6:0] FNUM_SECONDARY = 7'd1;

  typedef struct packed {
    logic [6:0]  field_number;
    logic [7:0]  data_byte_out;
    logic [13:0] length_value;
    logic        is_length;
    logic        field_last;
    logic        digit_error;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // ISO field number of a list entry
  function automatic logic [6:0] slot_number(input logic [4:0] s);
    logic [6:0] n;
    n = 7'd0;
    unique case (s)
      5'd0:  n = 7'd2;
      5'd1:  n = 7'd3;
      5'd2:  n = 7'd4;
      5'd3:  n = 7'd5;
      5'd4:  n = 7'd6;
      5'd5:  n = 7'd7;
      5'd6:  n = 7'd11;
      5'd7:  n = 7'd32;
      5'd8:  n = 7'd33;
      5'd9:  n = 7'd34;
      5'd10: n = 7'd38;
      5'd11: n = 7'd39;
      5'd12: n = 7'd40;
      5'd13: n = 7'd44;
      5'd14: n = 7'd45;
      5'd15: n = 7'd48;
      5'd16: n = 7'd104;
      5'd17: n = 7'd107;
      5'd18: n = 7'd108;
      5'd19: n = 7'd111;
      5'd20: n = 7'd127;
      default: n = 7'd0;
    endcase
    return n;
  endfunction

  // number of ASCII length digits; zero for fixed fields
  function automatic logic [2:0] slot_digits(input logic [4:0] s);
    logic [2:0] d;
    d = 3'd0;
    unique case (s)
      5'd0, 5'd7, 5'd8, 5'd9, 5'd13, 5'd14, 5'd17, 5'd18: d = 3'd2;
      5'd15, 5'd16, 5'd19:                                d = 3'd3;
      5'd20:                                              d = 3'd4;
      default:                                            d = 3'd0;
    endcase
    return d;
  endfunction

  function automatic logic [13:0] slot_fixed_len(input logic [4:0] s);
    logic [13:0] l;
    l = 14'd0;
    unique case (s)
      5'd1, 5'd6, 5'd10:       l = 14'd6;
      5'd2, 5'd3, 5'd4:        l = 14'd12;
      5'd5:                    l = 14'd10;
      5'd11:                   l = 14'd2;
      5'd12:                   l = 14'd3;
      default:                 l = 14'd0;
    endcase
    return l;
  endfunction

endpackage

@@ hw/rtl/i8p_front.sv @@
// Front end: accepts message bytes, tracks header and field walk, builds result records.
module i8p_front import i8p_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_start_of_message,
  input  fifo_stat_t q_stat,
  output logic       push,
  output res_t       push_data
);

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  logic [4:0]  hdr_r,   hdr_nxt;
  logic [63:0] prim_r,  prim_nxt;
  logic [63:0] sec_r,   sec_nxt;
  logic [4:0]  slot_r,  slot_nxt;
  logic        pfx_r,   pfx_nxt;
  logic [2:0]  dleft_r, dleft_nxt;
  logic [13:0] lacc_r,  lacc_nxt;
  logic [13:0] cleft_r, cleft_nxt;
  logic        perr_r,  perr_nxt;
  logic        done_r,  done_nxt;

  logic        accept;
  logic        go;
  logic [3:0]  dig;
  logic [20:0] present;
  logic [20:0] cand;
  logic        found_vld;
  logic [4:0]  found_idx;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // bitmap bit n sits at bit 64-n of the latched word
  always_comb begin
    for (int s = 0; s < 21; s++) begin
      if (slot_number(5'(s)) <= 7'd64) begin
        present[s] = prim_r[6'(7'd64 - slot_number(5'(s)))];
      end else begin
        present[s] = sec_r[6'(8'd128 - 8'(slot_number(5'(s))))];
      end
      cand[s] = present[s] && (5'(s) >= slot_r);
    end
  end

  // lowest present entry at or after the current slot
  always_comb begin
    found_vld = 1'b0;
    found_idx = SLOT_CNT;
    for (int s = 20; s >= 0; s--) begin
      if (cand[s]) begin
        found_vld = 1'b1;
        found_idx = 5'(s);
      end
    end
  end

  always_comb begin
    hdr_nxt   = hdr_r;
    prim_nxt  = prim_r;
    sec_nxt   = sec_r;
    slot_nxt  = slot_r;
    pfx_nxt   = pfx_r;
    dleft_nxt = dleft_r;
    lacc_nxt  = lacc_r;
    cleft_nxt = cleft_r;
    perr_nxt  = perr_r;
    done_nxt  = done_r;
    push      = 1'b0;
    push_data = '0;
    go        = 1'b0;
    dig       = 4'd0;
    if (accept) begin
      if (in_start_of_message) begin
        hdr_nxt   = '0;
        prim_nxt  = '0;
        sec_nxt   = '0;
        slot_nxt  = '0;
        pfx_nxt   = 1'b0;
        dleft_nxt = '0;
        lacc_nxt  = '0;
        cleft_nxt = '0;
        perr_nxt  = 1'b0;
        done_nxt  = 1'b0;
      end
      if (!done_nxt) begin
        if (hdr_nxt < HDR_LEN) begin
          if (hdr_nxt >= MTI_END && hdr_nxt < PRIM_END) begin
            prim_nxt                = {prim_nxt[55:0], in_data_byte};
            push                    = 1'b1;
            push_data.field_number  = FNUM_PRIMARY;
            push_data.data_byte_out = in_data_byte;
            push_data.field_last    = (hdr_nxt == PRIM_END - 5'd1);
          end else if (hdr_nxt >= PRIM_END) begin
            sec_nxt                 = {sec_nxt[55:0], in_data_byte};
            push                    = 1'b1;
            push_data.field_number  = FNUM_SECONDARY;
            push_data.data_byte_out = in_data_byte;
            push_data.field_last    = (hdr_nxt == HDR_LEN - 5'd1);
          end
          hdr_nxt = hdr_nxt + 5'd1;
        end else begin
          go = 1'b1;
          // between fields: pick the next present one
          if (!pfx_nxt && cleft_nxt == 14'd0) begin
            if (!found_vld) begin
              slot_nxt = SLOT_CNT;
              done_nxt = 1'b1;
              go       = 1'b0;
            end else begin
              slot_nxt = found_idx;
              if (slot_digits(found_idx) != 3'd0) begin
                pfx_nxt   = 1'b1;
                dleft_nxt = slot_digits(found_idx);
                lacc_nxt  = '0;
                perr_nxt  = 1'b0;
              end else begin
                cleft_nxt = slot_fixed_len(found_idx);
              end
            end
          end
          if (go) begin
            push_data.field_number = slot_number(slot_nxt);
            if (pfx_nxt) begin
              // non-digit counts as zero and flags the report
              if (in_data_byte >= ASCII_ZERO && in_data_byte <= ASCII_NINE) begin
                dig = in_data_byte[3:0];
              end else begin
                perr_nxt = 1'b1;
              end
              lacc_nxt = 14'((17'(lacc_nxt) << 3) + (17'(lacc_nxt) << 1) + 17'(dig));
              if (dleft_nxt != 3'd0) begin
                dleft_nxt = dleft_nxt - 3'd1;
              end
              if (dleft_nxt == 3'd0) begin
                pfx_nxt                = 1'b0;
                push                   = 1'b1;
                push_data.is_length    = 1'b1;
                push_data.length_value = lacc_nxt;
                push_data.field_last   = (lacc_nxt == 14'd0);
                push_data.digit_error  = perr_nxt;
                if (lacc_nxt == 14'd0) begin
                  slot_nxt = slot_nxt + 5'd1;
                end else begin
                  cleft_nxt = lacc_nxt;
                end
              end
            end else begin
              cleft_nxt               = cleft_nxt - 14'd1;
              push                    = 1'b1;
              push_data.data_byte_out = in_data_byte;
              push_data.field_last    = (cleft_nxt == 14'd0);
              if (cleft_nxt == 14'd0) begin
                slot_nxt = slot_nxt + 5'd1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r   <= '0;
      prim_r  <= '0;
      sec_r   <= '0;
      slot_r  <= '0;
      pfx_r   <= 1'b0;
      dleft_r <= '0;
      lacc_r  <= '0;
      cleft_r <= '0;
      perr_r  <= 1'b0;
      done_r  <= 1'b1;
    end else begin
      hdr_r   <= hdr_nxt;
      prim_r  <= prim_nxt;
      sec_r   <= sec_nxt;
      slot_r  <= slot_nxt;
      pfx_r   <= pfx_nxt;
      dleft_r <= dleft_nxt;
      lacc_r  <= lacc_nxt;
      cleft_r <= cleft_nxt;
      perr_r  <= perr_nxt;
      done_r  <= done_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n) hdr_r <= HDR_LEN)
    else $error("header position past end");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n) slot_r <= SLOT_CNT)
    else $error("field slot past end");
  a_pfx_excl: assert property (@(posedge clk) disable iff (!rst_n)
      pfx_r |-> (dleft_r != 3'd0 && cleft_r == 14'd0))
    else $error("length prefix state inconsistent");
`endif

endmodule

@@ hw/rtl/i8p_fifo.sv @@
// Short result queue between the parsing front end and the output stage.
module i8p_fifo import i8p_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  res_t       push_data,
  input  logic       pop,
  output res_t       pop_data,
  output fifo_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  res_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign stat.full  = (count_r == FULL_CNT);
  assign stat.empty = (count_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) count_r <= FULL_CNT)
    else $error("queue count overflow");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n) stat.full |-> !push)
    else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n) stat.empty |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

@@ hw/rtl/i8p_back.sv @@
// Back end: drains the result queue into the registered output channel.
module i8p_back import i8p_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fifo_stat_t  q_stat,
  input  res_t        q_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_field_number,
  output logic [7:0]  out_data_byte_out,
  output logic [13:0] out_length_value,
  output logic        out_is_length,
  output logic        out_field_last,
  output logic        out_digit_error
);

  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  // refill whenever the output register is free or being taken
  assign pop = !q_stat.empty && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_field_number  = res_r.field_number;
  assign out_data_byte_out = res_r.data_byte_out;
  assign out_length_value  = res_r.length_value;
  assign out_is_length     = res_r.is_length;
  assign out_field_last    = res_r.field_last;
  assign out_digit_error   = res_r.digit_error;

endmodule

@@ hw/rtl/iso8583_response_field_parser.sv @@
// Results pass through the result queue and the output register. One byte per cycle is
// taken while the queue is not full; the front end finds the next field in the same cycle.
// Header bytes (length prefix, MTI) and dropped trailing bytes give no result.
// Reset: synchronous, active low; queue and output empty, parser waits for a start byte.
// The queue holds FIFO_DEPTH results, so input keeps running while out stalls, until full.
module iso8583_response_field_parser import i8p_pkg::*; #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_field_number,
  output logic [7:0]  out_data_byte_out,
  output logic [13:0] out_length_value,
  output logic        out_is_length,
  output logic        out_field_last,
  output logic        out_digit_error
);

  fifo_stat_t q_stat;
  logic       push;
  res_t       push_data;
  logic       pop;
  res_t       pop_data;

  // front end: header skip, bitmap latch, field walk, length decode
  i8p_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_start_of_message (in_start_of_message),
    .q_stat              (q_stat),
    .push                (push),
    .push_data           (push_data)
  );

  // decouples the parser from output back-pressure
  i8p_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  // registered result channel
  i8p_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_data            (pop_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_field_number  (out_field_number),
    .out_data_byte_out (out_data_byte_out),
    .out_length_value  (out_length_value),
    .out_is_length     (out_is_length),
    .out_field_last    (out_field_last),
    .out_digit_error   (out_digit_error)
  );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the ISO 8583 response field parser.
`timescale 1ns / 100ps

module tb;
  import i8p_pkg::*;

  // Generous ceiling on the run, even with heavy stalls on both sides.
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int RANDOM_REQUESTS = 900;
  // A result passes through the small output queue and the output register.
  localparam int SETTLE_CYCLES   = 12;

  // How the length digits of variable fields are chosen.
  typedef enum int {
    LEN_SHORT,  // mostly short, some zero, some with a non-digit character
    LEN_MAX     // all nines: the longest field each prefix allows
  } len_mode_t;

  // One entry of the supported field list.
  typedef struct packed {
    logic [6:0]  num;
    logic [2:0]  digits;     // ASCII length digits, zero for a fixed field
    logic [13:0] fixed_len;
  } list_entry_t;

  // One request for the input channel.
  typedef struct packed {
    logic [7:0] data;
    logic       som;
    logic       hold;        // wait for every result to drain before sending
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_start_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_field_number;
  logic [7:0]  out_data_byte_out;
  logic [13:0] out_length_value;
  logic        out_is_length;
  logic        out_field_last;
  logic        out_digit_error;

  iso8583_response_field_parser i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_start_of_message (in_start_of_message),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_field_number    (out_field_number),
    .out_data_byte_out   (out_data_byte_out),
    .out_length_value    (out_length_value),
    .out_is_length       (out_is_length),
    .out_field_last      (out_field_last),
    .out_digit_error     (out_digit_error)
  );

  // Requests waiting to be sent, and field results still owed by the block.
  byte_req_t pending_bytes[$];
  res_t      owed_results[$];

  int n_queued   = 0;  // requests put in the pending queue
  int n_sent     = 0;  // requests presented on the input port
  int n_taken    = 0;  // requests accepted by the block
  int mismatches = 0;
  int cycles     = 0;

  // Parser state as the block should hold it. Reset leaves it waiting for a
  // start byte.
  logic [4:0]  hdr_pos      = '0;
  logic [63:0] prim_map     = '0;
  logic [63:0] sec_map      = '0;
  logic [4:0]  slot         = '0;
  logic        in_prefix    = 1'b0;
  logic [2:0]  digits_left  = '0;
  logic [13:0] len_acc      = '0;
  logic [13:0] content_left = '0;
  logic        prefix_err   = 1'b0;
  logic        msg_done     = 1'b1;

  // Supported field list, ascending field number.
  function automatic list_entry_t slot_info(input int s);
    list_entry_t e;
    case (s)
      0:       e = '{7'd2,   3'd2, 14'd0};
      1:       e = '{7'd3,   3'd0, 14'd6};
      2:       e = '{7'd4,   3'd0, 14'd12};
      3:       e = '{7'd5,   3'd0, 14'd12};
      4:       e = '{7'd6,   3'd0, 14'd12};
      5:       e = '{7'd7,   3'd0, 14'd10};
      6:       e = '{7'd11,  3'd0, 14'd6};
      7:       e = '{7'd32,  3'd2, 14'd0};
      8:       e = '{7'd33,  3'd2, 14'd0};
      9:       e = '{7'd34,  3'd2, 14'd0};
      10:      e = '{7'd38,  3'd0, 14'd6};
      11:      e = '{7'd39,  3'd0, 14'd2};
      12:      e = '{7'd40,  3'd0, 14'd3};
      13:      e = '{7'd44,  3'd2, 14'd0};
      14:      e = '{7'd45,  3'd2, 14'd0};
      15:      e = '{7'd48,  3'd3, 14'd0};
      16:      e = '{7'd104, 3'd3, 14'd0};
      17:      e = '{7'd107, 3'd2, 14'd0};
      18:      e = '{7'd108, 3'd2, 14'd0};
      19:      e = '{7'd111, 3'd3, 14'd0};
      default: e = '{7'd127, 3'd4, 14'd0};
    endcase
    return e;
  endfunction

  // Bitmap bit of field n: 1..64 in the primary map, 65..128 in the secondary,
  // most significant bit first.
  function automatic logic map_bit(input logic [63:0] pm, input logic [63:0] sm,
                                   input int n);
    return (n <= 64) ? pm[64 - n] : sm[128 - n];
  endfunction

  // Work out the result, if any, that one accepted request should give.
  function automatic void predict_request(input logic [7:0] b, input logic som);
    res_t        r;
    logic [4:0]  p;
    int          s;
    list_entry_t e;
    logic [13:0] d;
    logic [6:0]  fnum;
    r = '0;
    // a start byte restarts the parse wherever it was
    if (som) begin
      hdr_pos      = '0;
      prim_map     = '0;
      sec_map      = '0;
      slot         = '0;
      in_prefix    = 1'b0;
      digits_left  = '0;
      len_acc      = '0;
      content_left = '0;
      prefix_err   = 1'b0;
      msg_done     = 1'b0;
    end
    if (msg_done)
      return;

    // header: length prefix and MTI are silent, bitmap bytes pass through
    if (hdr_pos < HDR_LEN) begin
      p = hdr_pos;
      hdr_pos = hdr_pos + 5'd1;
      if (p < MTI_END)
        return;
      r.data_byte_out = b;
      if (p < PRIM_END) begin
        prim_map = {prim_map[55:0], b};
        r.field_number = FNUM_PRIMARY;
        r.field_last = (p == PRIM_END - 5'd1);
      end else begin
        sec_map = {sec_map[55:0], b};
        r.field_number = FNUM_SECONDARY;
        r.field_last = (p == HDR_LEN - 5'd1);
      end
      owed_results.push_back(r);
      return;
    end

    // between fields: find the next present one, or finish the message
    if (!in_prefix && content_left == 14'd0) begin
      s = int'(slot);
      while (s < int'(SLOT_CNT) && !map_bit(prim_map, sec_map, int'(slot_info(s).num)))
        s++;
      if (s >= int'(SLOT_CNT)) begin
        slot = SLOT_CNT;
        msg_done = 1'b1;
        return;
      end
      slot = 5'(s);
      e = slot_info(s);
      if (e.digits != 3'd0) begin
        in_prefix   = 1'b1;
        digits_left = e.digits;
        len_acc     = '0;
        prefix_err  = 1'b0;
      end else begin
        content_left = e.fixed_len;
      end
    end

    fnum = slot_info(int'(slot)).num;
    r.field_number = fnum;

    // length digits: a non-digit counts as zero and marks the report
    if (in_prefix) begin
      if (b >= 8'h30 && b <= 8'h39) begin
        d = {6'd0, b - 8'h30};
      end else begin
        d = '0;
        prefix_err = 1'b1;
      end
      len_acc = len_acc * 14'd10 + d;
      if (digits_left != 3'd0)
        digits_left = digits_left - 3'd1;
      if (digits_left != 3'd0)
        return;
      in_prefix = 1'b0;
      r.length_value = len_acc;
      r.is_length    = 1'b1;
      r.field_last   = (len_acc == 14'd0);
      r.digit_error  = prefix_err;
      owed_results.push_back(r);
      if (len_acc == 14'd0)
        slot = slot + 5'd1;
      else
        content_left = len_acc;
      return;
    end

    // content byte
    content_left = content_left - 14'd1;
    r.data_byte_out = b;
    r.field_last = (content_left == 14'd0);
    owed_results.push_back(r);
    if (content_left == 14'd0)
      slot = slot + 5'd1;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void push_req(input logic [7:0] b, input logic som,
                                   input logic hold);
    byte_req_t rq;
    rq.data = b;
    rq.som  = som;
    rq.hold = hold;
    pending_bytes.push_back(rq);
    n_queued++;
  endfunction

  // Build one whole message from two bitmaps; cut_at >= 0 truncates it there,
  // so that the next start byte lands in the middle of the parse.
  function automatic void queue_message(input logic [63:0] pm, input logic [63:0] sm,
                                        input len_mode_t mode, input int cut_at,
                                        input logic hold);
    logic [7:0]  msg[$];
    logic [7:0]  ch[4];
    list_entry_t e;
    int          i;
    int          k;
    int          s;
    int          target;
    int          eff;
    int          nd;
    logic [7:0]  c;
    // length prefix and MTI, ASCII digits
    for (i = 0; i < int'(MTI_END); i++)
      msg.push_back(8'h30 + 8'($urandom_range(0, 9)));
    for (i = 0; i < 8; i++)
      msg.push_back(pm[63 - 8 * i -: 8]);
    for (i = 0; i < 8; i++)
      msg.push_back(sm[63 - 8 * i -: 8]);
    for (s = 0; s < int'(SLOT_CNT); s++) begin
      e = slot_info(s);
      if (!map_bit(pm, sm, int'(e.num)))
        continue;
      if (e.digits == 3'd0) begin
        for (i = 0; i < int'(e.fixed_len); i++)
          msg.push_back(8'($urandom_range(0, 255)));
        continue;
      end
      nd = int'(e.digits);
      if (mode == LEN_MAX)
        target = (nd == 2) ? 99 : (nd == 3) ? 999 : 9999;
      else if ($urandom_range(0, 5) == 0)
        target = 0;
      else if ($urandom_range(0, 15) == 0)
        target = $urandom_range(13, 40);
      else
        target = $urandom_range(1, 12);
      for (k = nd - 1; k >= 0; k--) begin
        ch[k] = 8'h30 + 8'(target % 10);
        target = target / 10;
      end
      // spoil one length character now and then, boundaries included
      if (mode == LEN_SHORT && $urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0:       c = 8'h2F;
          1:       c = 8'h3A;
          2:       c = 8'hFF;
          default: begin
            c = 8'($urandom_range(0, 255));
            if (c >= 8'h30 && c <= 8'h39)
              c = c ^ 8'h80;
          end
        endcase
        ch[$urandom_range(0, nd - 1)] = c;
      end
      // content length as the block will read it
      eff = 0;
      for (k = 0; k < nd; k++) begin
        eff = eff * 10;
        if (ch[k] >= 8'h30 && ch[k] <= 8'h39)
          eff = eff + int'(ch[k] - 8'h30);
        msg.push_back(ch[k]);
      end
      for (i = 0; i < eff; i++)
        msg.push_back(8'($urandom_range(0, 255)));
    end
    if (cut_at >= 0 && cut_at < msg.size())
      msg = msg[0:cut_at - 1];
    for (i = 0; i < msg.size(); i++)
      push_req(msg[i], i == 0, hold && i == 0);
  endfunction

  // Random bitmap: every bit random, then each listed field present with
  // probability one in den.
  function automatic void random_maps(output logic [63:0] pm, output logic [63:0] sm,
                                      input int den);
    int s;
    int n;
    logic v;
    pm = {$urandom, $urandom};
    sm = {$urandom, $urandom};
    for (s = 0; s < int'(SLOT_CNT); s++) begin
      n = int'(slot_info(s).num);
      v = ($urandom_range(1, den) == 1);
      if (n <= 64)
        pm[64 - n] = v;
      else
        sm[128 - n] = v;
    end
  endfunction

  // Clock, 20 ns period.
  initial begin
    forever #10 clk = ~clk;
  end

  // Sender: bursts of random length with random gaps, one request at a time,
  // valid held until the block takes it.
  int        burst_left = 0;
  int        gap_left   = 0;
  byte_req_t next_req;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && n_taken != n_sent)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() == 0 ||
                   (pending_bytes[0].hold && owed_results.size() != 0)) begin
        // nothing left, or a pause until every owed result has come back
        in_valid <= 1'b0;
      end else begin
        next_req = pending_bytes.pop_front();
        in_data_byte        <= next_req.data;
        in_start_of_message <= next_req.som;
        in_valid            <= 1'b1;
        n_sent++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // about one burst in four runs straight on into the next
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: ready follows a rotating 16-bit pattern, reloaded whenever stall_age wraps;
  // some reloads are all ones so there are stretches with no stall.
  logic [15:0] stall_pat = 16'hFFFF;
  int          stall_age = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_age == 63) begin
        stall_age = 0;
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      end else begin
        stall_age++;
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
      out_ready <= stall_pat[0];
    end
  end

  // Monitor: checks each accepted result against the oldest owed one, then
  // predicts from the request accepted at this edge. A result is never due in
  // the cycle of its own request, so the order here is safe.
  res_t seen;
  res_t want;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycles, owed_results.size());
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        seen = '{out_field_number, out_data_byte_out, out_length_value,
                 out_is_length, out_field_last, out_digit_error};
        if (owed_results.size() == 0) begin
          flag_mismatch("unexpected result, field_number", seen.field_number, -1);
        end else begin
          want = owed_results.pop_front();
          if (seen.field_number !== want.field_number)
            flag_mismatch("field_number", seen.field_number, want.field_number);
          if (seen.data_byte_out !== want.data_byte_out)
            flag_mismatch("data_byte_out", seen.data_byte_out, want.data_byte_out);
          if (seen.length_value !== want.length_value)
            flag_mismatch("length_value", seen.length_value, want.length_value);
          if (seen.is_length !== want.is_length)
            flag_mismatch("is_length", seen.is_length, want.is_length);
          if (seen.field_last !== want.field_last)
            flag_mismatch("field_last", seen.field_last, want.field_last);
          if (seen.digit_error !== want.digit_error)
            flag_mismatch("digit_error", seen.digit_error, want.digit_error);
        end
      end
      if (in_valid && in_ready) begin
        predict_request(in_data_byte, in_start_of_message);
        n_taken++;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [63:0] pm;
    logic [63:0] sm;
    int          goal;
    int          i;
    int          cut;

    // Directed part.
    // Bytes before any start byte are ignored.
    push_req(8'h00, 1'b0, 1'b0);
    push_req(8'hFF, 1'b0, 1'b0);
    push_req(8'h5A, 1'b0, 1'b0);
    // Empty bitmaps, bit 1 clear: secondary map still read, no fields; the
    // first trailing byte ends the message and the next is dropped.
    queue_message(64'h0, 64'h0, LEN_SHORT, -1, 1'b0);
    push_req(8'hFF, 1'b0, 1'b0);
    push_req(8'h00, 1'b0, 1'b0);
    // Every field present, short lengths, sent only once all is drained.
    queue_message('1, '1, LEN_SHORT, -1, 1'b1);
    push_req(8'hA5, 1'b0, 1'b0);
    // Longest LL fields, whole (2 and 107).
    queue_message(64'h4000_0000_0000_0000, 64'h0000_0000_0020_0000, LEN_MAX, -1, 1'b0);
    push_req(8'h00, 1'b0, 1'b0);
    // Longest LLL and LLLL lengths (48 and 127), cut a few bytes after the report.
    queue_message(64'h0000_0000_0001_0000, 64'h0, LEN_MAX, 33, 1'b0);
    queue_message(64'h0, 64'h0000_0000_0000_0002, LEN_MAX, 34, 1'b0);
    // Start byte in the middle of a field.
    queue_message('1, '1, LEN_SHORT, 40, 1'b0);

    // Random part: mostly whole messages, some cut short, noise in between.
    goal = n_queued + RANDOM_REQUESTS;
    while (n_queued < goal) begin
      random_maps(pm, sm, $urandom_range(2, 4));
      if ($urandom_range(0, 15) == 0) begin
        for (i = $urandom_range(1, 3); i > 0; i--)
          push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 120) : -1;
      queue_message(pm, sm, LEN_SHORT, cut, $urandom_range(0, 9) == 0);
      if ($urandom_range(0, 2) == 0) begin
        for (i = $urandom_range(1, 3); i > 0; i--)
          push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every request taken, every owed result back, then a short settle
    while (pending_bytes.size() != 0 || n_taken != n_sent)
      @(posedge clk);
    while (owed_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
